// ===== hw/rtl/vector3_alu_assert.svh =====
// Assertion macros for the vector ALU checker.
// Needs clk and rst_n in scope where the macros are used.
`ifndef VECTOR3_ALU_ASSERT_SVH
`define VECTOR3_ALU_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define V3A_CHECK_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector3_alu check failed");

// The expression must never hold.
`define V3A_CHECK_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("vector3_alu check failed");

`endif

// ===== hw/rtl/v3a_pkg.sv =====
// Package for the vector ALU: transaction types, opcodes, pipeline records
// and the saturation helper. Depends on nothing.
`timescale 1ns / 1ps

package v3a_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int SQRT_STEPS = 32;
    localparam int DIVD_W     = DATA_W + FRAC_W;
    localparam int DIV_STEPS  = DIVD_W;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_NEG   = 4'd2,
        OP_ADDS  = 4'd3,
        OP_SUBS  = 4'd4,
        OP_MULS  = 4'd5,
        OP_DIVS  = 4'd6,
        OP_DOT   = 4'd7,
        OP_CROSS = 4'd8,
        OP_LEN   = 4'd9,
        OP_NORM  = 4'd10,
        OP_EQ    = 4'd11
    } op_t;

    typedef logic signed [31:0] word_t;

    typedef struct packed {
        logic [3:0] func;
        word_t      a_x;
        word_t      a_y;
        word_t      a_z;
        word_t      b_x;
        word_t      b_y;
        word_t      b_z;
        word_t      scalar_in;
    } in_item_t;

    typedef struct packed {
        word_t r_x;
        word_t r_y;
        word_t r_z;
        word_t scalar_out;
        logic  equal_flag;
        logic  overflow_flag;
        logic  div_error;
    } out_item_t;

    typedef struct packed {
        logic [31:0] val;
        logic        ov;
    } sat_t;

    // Record that travels alongside the square root pipeline.
    typedef struct packed {
        logic [3:0]       func;
        logic [2:0][31:0] r;
        logic [31:0]      sc;
        logic             eq;
        logic             ov;
        logic [31:0]      s_mag;
        logic             s_neg;
        logic             s_zero;
        logic [2:0]       a_neg;
        logic [2:0][31:0] a_mag;
    } early_t;

    // Record that travels alongside the divider pipelines.
    typedef struct packed {
        logic [3:0]       func;
        logic [2:0][31:0] r;
        logic [31:0]      sc;
        logic             eq;
        logic             ov;
        logic             dz;
    } late_t;

    localparam logic signed [65:0] VMAX66 = 66'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [65:0] VMIN66 = 66'sh3_FFFF_FFFF_8000_0000;

    function automatic logic signed [65:0] sext66(input logic signed [63:0] v);
        return {{2{v[63]}}, v};
    endfunction

    function automatic sat_t sat_word(input logic signed [65:0] v);
        sat_t res;
        if (v > VMAX66)
        begin
            res.val = 32'h7FFF_FFFF;
            res.ov  = 1'b1;
        end
        else if (v < VMIN66)
        begin
            res.val = 32'h8000_0000;
            res.ov  = 1'b1;
        end
        else
        begin
            res.val = v[31:0];
            res.ov  = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/v3a_lane.sv =====
// One component lane: multipliers, add/subtract and the per-lane results.
// Depends on v3a_pkg.
`timescale 1ns / 1ps

module v3a_lane (
    input  logic          clk,
    input  logic [3:0]    func,
    input  v3a_pkg::word_t a_self,
    input  v3a_pkg::word_t b_self,
    input  v3a_pkg::word_t a_next,
    input  v3a_pkg::word_t b_next,
    input  v3a_pkg::word_t a_last,
    input  v3a_pkg::word_t b_last,
    input  v3a_pkg::word_t s,
    output logic signed [63:0] prod,
    output v3a_pkg::word_t r,
    output logic          ov,
    output logic          eq,
    output logic          a_neg,
    output logic [31:0]   a_mag
);
    import v3a_pkg::*;

    word_t              op_a;
    word_t              op_b;
    logic signed [33:0] ea;
    logic signed [33:0] eb;
    logic signed [33:0] es;
    logic signed [33:0] simp_next;
    logic               is_simp_next;

    logic signed [63:0] prod0_reg;
    logic signed [63:0] prod1_reg;
    logic signed [33:0] simp_reg;
    logic               is_simp_reg;
    logic [3:0]         func1_reg;
    logic               eq1_reg;
    logic               a_neg1_reg;
    logic [31:0]        a_mag1_reg;

    logic signed [65:0] mul_sh;
    logic signed [65:0] crs_diff;
    logic signed [65:0] crs_sh;
    sat_t               res_next;

    logic [31:0]        r_reg;
    logic               ov_reg;
    logic               eq_reg;
    logic               a_neg_reg;
    logic [31:0]        a_mag_reg;

    always_comb
    begin
        op_a = a_self;
        op_b = b_self;
        unique case (func)
            OP_MULS:          op_b = s;
            OP_LEN, OP_NORM:  op_b = a_self;
            OP_CROSS:
            begin
                op_a = a_next;
                op_b = b_last;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ea = $signed({{2{a_self[31]}}, a_self});
        eb = $signed({{2{b_self[31]}}, b_self});
        es = $signed({{2{s[31]}}, s});
        simp_next    = ea + eb;
        is_simp_next = 1'b1;
        unique case (func)
            OP_ADD:  simp_next = ea + eb;
            OP_SUB:  simp_next = ea - eb;
            OP_NEG:  simp_next = -ea;
            OP_ADDS: simp_next = ea + es;
            OP_SUBS: simp_next = ea - es;
            default:
            begin
                simp_next    = '0;
                is_simp_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod0_reg   <= op_a * op_b;
        prod1_reg   <= a_last * b_next;
        simp_reg    <= simp_next;
        is_simp_reg <= is_simp_next;
        func1_reg   <= func;
        eq1_reg     <= (a_self == b_self);
        a_neg1_reg  <= a_self[31];
        a_mag1_reg  <= a_self[31] ? 32'(-a_self) : 32'(a_self);
    end

    // Arithmetic right shift of the exact product is a floor by 2^FRAC_W.
    assign mul_sh   = sext66(prod0_reg) >>> FRAC_W;
    assign crs_diff = sext66(prod0_reg) - sext66(prod1_reg);
    assign crs_sh   = crs_diff >>> FRAC_W;

    always_comb
    begin
        res_next = '0;
        if (is_simp_reg)
        begin
            res_next = sat_word($signed({{32{simp_reg[33]}}, simp_reg}));
        end
        else
        begin
            unique case (func1_reg)
                OP_MULS:  res_next = sat_word(mul_sh);
                OP_CROSS: res_next = sat_word(crs_sh);
                default:  res_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= res_next.val;
        ov_reg    <= res_next.ov;
        eq_reg    <= eq1_reg;
        a_neg_reg <= a_neg1_reg;
        a_mag_reg <= a_mag1_reg;
    end

    assign prod  = prod0_reg;
    assign r     = r_reg;
    assign ov    = ov_reg;
    assign eq    = eq_reg;
    assign a_neg = a_neg_reg;
    assign a_mag = a_mag_reg;

endmodule

// ===== hw/rtl/v3a_merge.sv =====
// Merging stage: sums the lane products into the dot product and the
// squared length, and prepares the scalar operand. Depends on v3a_pkg.
`timescale 1ns / 1ps

module v3a_merge (
    input  logic               clk,
    input  logic [3:0]         func,
    input  v3a_pkg::word_t     s,
    input  logic signed [63:0] prod0,
    input  logic signed [63:0] prod1,
    input  logic signed [63:0] prod2,
    output logic [3:0]         func_out,
    output logic [31:0]        dot_sc,
    output logic               dot_ov,
    output logic [63:0]        sq_sum,
    output logic [31:0]        s_mag,
    output logic               s_neg,
    output logic               s_zero
);
    import v3a_pkg::*;

    logic signed [65:0] dot_sum;
    logic signed [65:0] dot_sh;
    sat_t               dot_res;

    logic [3:0]  func_reg;
    logic [31:0] dot_sc_reg;
    logic        dot_ov_reg;
    logic [63:0] sq_sum_reg;
    logic [31:0] s_mag_reg;
    logic        s_neg_reg;
    logic        s_zero_reg;

    assign dot_sum = sext66(prod0) + sext66(prod1) + sext66(prod2);
    assign dot_sh  = dot_sum >>> FRAC_W;

    always_comb
    begin
        dot_res = '0;
        if (func == OP_DOT)
        begin
            dot_res = sat_word(dot_sh);
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func;
        dot_sc_reg <= dot_res.val;
        dot_ov_reg <= dot_res.ov;
        // Squares are never negative, so the unsigned sum is exact.
        sq_sum_reg <= 64'(prod0) + 64'(prod1) + 64'(prod2);
        s_mag_reg  <= s[31] ? 32'(-s) : 32'(s);
        s_neg_reg  <= s[31];
        s_zero_reg <= (s == '0);
    end

    assign func_out = func_reg;
    assign dot_sc   = dot_sc_reg;
    assign dot_ov   = dot_ov_reg;
    assign sq_sum   = sq_sum_reg;
    assign s_mag    = s_mag_reg;
    assign s_neg    = s_neg_reg;
    assign s_zero   = s_zero_reg;

endmodule

// ===== hw/rtl/v3a_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, carrying the
// early result record alongside. Depends on v3a_pkg.
`timescale 1ns / 1ps

module v3a_sqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [63:0]     radicand,
    input  v3a_pkg::early_t side_in,
    output logic            out_valid,
    output logic [31:0]     root,
    output v3a_pkg::early_t side_out
);
    import v3a_pkg::*;

    logic        valid_reg [SQRT_STEPS];
    logic [33:0] rem_reg   [SQRT_STEPS];
    logic [31:0] root_reg  [SQRT_STEPS];
    logic [63:0] n_reg     [SQRT_STEPS];
    early_t      side_reg  [SQRT_STEPS];

    genvar k;
    for (k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic        v_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] n_in;
        early_t      s_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic        fit;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = radicand;
            assign s_in    = side_in;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign n_in    = n_reg[k-1];
            assign s_in    = side_reg[k-1];
        end

        // Bring down the next two radicand bits and try root*4+1.
        assign rem_sh = {rem_in, n_in[63:62]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign fit    = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= fit ? 34'(rem_sh - trial) : rem_sh[33:0];
            root_reg[k] <= {root_in[30:0], fit};
            n_reg[k]    <= {n_in[61:0], 2'b00};
            side_reg[k] <= s_in;
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign root      = root_reg[SQRT_STEPS-1];
    assign side_out  = side_reg[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/v3a_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// one-bit tag carried alongside. Depends on v3a_pkg.
`timescale 1ns / 1ps

module v3a_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [v3a_pkg::DIVD_W-1:0] dividend,
    input  logic [31:0]                divisor,
    input  logic                       tag_in,
    output logic                       out_valid,
    output logic [v3a_pkg::DIVD_W-1:0] quotient,
    output logic                       tag_out
);
    import v3a_pkg::*;

    logic              valid_reg [DIV_STEPS];
    logic [31:0]       rem_reg   [DIV_STEPS];
    logic [DIVD_W-1:0] d_reg     [DIV_STEPS];
    logic [DIVD_W-1:0] q_reg     [DIV_STEPS];
    logic [31:0]       dvs_reg   [DIV_STEPS];
    logic              tag_reg   [DIV_STEPS];

    genvar k;
    for (k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic              v_in;
        logic [31:0]       rem_in;
        logic [DIVD_W-1:0] d_in;
        logic [DIVD_W-1:0] q_in;
        logic [31:0]       dvs_in;
        logic              t_in;
        logic [32:0]       rem_sh;
        logic              fit;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign d_in   = dividend;
            assign q_in   = '0;
            assign dvs_in = divisor;
            assign t_in   = tag_in;
        end
        else
        begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign t_in   = tag_reg[k-1];
        end

        assign rem_sh = {rem_in, d_in[DIVD_W-1]};
        assign fit    = (rem_sh >= {1'b0, dvs_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= fit ? 32'(rem_sh - {1'b0, dvs_in}) : rem_sh[31:0];
            d_reg[k]   <= {d_in[DIVD_W-2:0], 1'b0};
            q_reg[k]   <= {q_in[DIVD_W-2:0], fit};
            dvs_reg[k] <= dvs_in;
            tag_reg[k] <= t_in;
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign quotient  = q_reg[DIV_STEPS-1];
    assign tag_out   = tag_reg[DIV_STEPS-1];

endmodule

// ===== hw/rtl/vector3_alu.sv =====
// Three-component vector ALU on signed Q16.16 operands. A transaction is taken
// on every clock edge at which start is high; busy never rises, so one
// transaction per cycle is sustained. Every transaction gives exactly one
// result, shown on result with done high for one cycle, in order. All opcodes
// take the same path through the 32-stage square root pipeline followed by the
// 48-stage divider pipelines that serve length, normalize and divide-by-scalar.
// The receiver cannot stall the block, so results must be taken as they appear.
// Depends on v3a_pkg, v3a_lane, v3a_merge, v3a_sqrt and v3a_div.
`timescale 1ns / 1ps

module vector3_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  v3a_pkg::in_item_t  cmd,
    output logic               done,
    output v3a_pkg::out_item_t result
);
    import v3a_pkg::*;

    logic        accept;
    in_item_t    in_reg;
    logic        v0_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic [3:0]  func1_reg;
    word_t       s1_reg;

    word_t              a_vec   [3];
    word_t              b_vec   [3];
    logic signed [63:0] lane_prod [3];
    word_t              lane_r    [3];
    logic [2:0]         lane_ov;
    logic [2:0]         lane_eq;
    logic [2:0]         lane_neg;
    logic [31:0]        lane_mag  [3];

    logic [3:0]  func2;
    logic [31:0] dot_sc;
    logic        dot_ov;
    logic [63:0] sq_sum;
    logic [31:0] s_mag;
    logic        s_neg;
    logic        s_zero;

    early_t      early_in;
    early_t      early_out;
    logic        sq_valid;
    logic [31:0] root;
    sat_t        len_res;
    late_t       late_in;
    late_t       late_pipe [DIV_STEPS];
    logic        is_divs;
    logic        is_norm;

    logic [31:0]       dvs      [3];
    logic [DIVD_W-1:0] dvd      [3];
    logic [2:0]        tag_in;
    logic [2:0]        div_valid;
    logic [DIVD_W-1:0] quot     [3];
    logic [2:0]        tag_out;

    late_t              fin;
    logic [2:0][31:0]   fin_r;
    logic               fin_ov;
    logic signed [65:0] qs;
    sat_t               q_res;
    out_item_t          out_next;
    out_item_t          out_reg;
    logic               done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= accept;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            done_reg <= &div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg    <= cmd;
        func1_reg <= in_reg.func;
        s1_reg    <= in_reg.scalar_in;
    end

    assign a_vec[0] = in_reg.a_x;
    assign a_vec[1] = in_reg.a_y;
    assign a_vec[2] = in_reg.a_z;
    assign b_vec[0] = in_reg.b_x;
    assign b_vec[1] = in_reg.b_y;
    assign b_vec[2] = in_reg.b_z;

    genvar i;
    for (i = 0; i < 3; i++)
    begin : g_lane
        v3a_lane u_lane (
            .clk    (clk),
            .func   (in_reg.func),
            .a_self (a_vec[i]),
            .b_self (b_vec[i]),
            .a_next (a_vec[(i + 1) % 3]),
            .b_next (b_vec[(i + 1) % 3]),
            .a_last (a_vec[(i + 2) % 3]),
            .b_last (b_vec[(i + 2) % 3]),
            .s      (in_reg.scalar_in),
            .prod   (lane_prod[i]),
            .r      (lane_r[i]),
            .ov     (lane_ov[i]),
            .eq     (lane_eq[i]),
            .a_neg  (lane_neg[i]),
            .a_mag  (lane_mag[i])
        );
    end

    v3a_merge u_merge (
        .clk      (clk),
        .func     (func1_reg),
        .s        (s1_reg),
        .prod0    (lane_prod[0]),
        .prod1    (lane_prod[1]),
        .prod2    (lane_prod[2]),
        .func_out (func2),
        .dot_sc   (dot_sc),
        .dot_ov   (dot_ov),
        .sq_sum   (sq_sum),
        .s_mag    (s_mag),
        .s_neg    (s_neg),
        .s_zero   (s_zero)
    );

    always_comb
    begin
        early_in.func   = func2;
        early_in.sc     = dot_sc;
        early_in.eq     = (func2 == OP_EQ) && (&lane_eq);
        early_in.ov     = (|lane_ov) || dot_ov;
        early_in.s_mag  = s_mag;
        early_in.s_neg  = s_neg;
        early_in.s_zero = s_zero;
        early_in.a_neg  = lane_neg;
        for (int j = 0; j < 3; j++)
        begin
            early_in.r[j]     = lane_r[j];
            early_in.a_mag[j] = lane_mag[j];
        end
    end

    v3a_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .radicand  (sq_sum),
        .side_in   (early_in),
        .out_valid (sq_valid),
        .root      (root),
        .side_out  (early_out)
    );

    assign is_divs = (early_out.func == OP_DIVS);
    assign is_norm = (early_out.func == OP_NORM);

    always_comb
    begin
        len_res      = sat_word($signed({34'b0, root}));
        late_in.func = early_out.func;
        late_in.r    = early_out.r;
        late_in.eq   = early_out.eq;
        late_in.sc   = early_out.sc;
        late_in.ov   = early_out.ov;
        if (early_out.func == OP_LEN)
        begin
            late_in.sc = len_res.val;
            late_in.ov = early_out.ov || len_res.ov;
        end
        late_in.dz = (is_divs && early_out.s_zero) || (is_norm && (root == '0));
    end

    for (i = 0; i < 3; i++)
    begin : g_div
        assign dvs[i]    = is_norm ? root : early_out.s_mag;
        assign dvd[i]    = {early_out.a_mag[i], {FRAC_W{1'b0}}};
        assign tag_in[i] = early_out.a_neg[i] ^ (is_divs && early_out.s_neg);

        v3a_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid),
            .dividend  (dvd[i]),
            .divisor   (dvs[i]),
            .tag_in    (tag_in[i]),
            .out_valid (div_valid[i]),
            .quotient  (quot[i]),
            .tag_out   (tag_out[i])
        );
    end

    // The transaction record waits here while the dividers work.
    always_ff @(posedge clk)
    begin
        late_pipe[0] <= late_in;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            late_pipe[k] <= late_pipe[k-1];
        end
    end

    always_comb
    begin
        fin    = late_pipe[DIV_STEPS-1];
        fin_r  = fin.r;
        fin_ov = fin.ov;
        qs     = '0;
        q_res  = '0;
        if (fin.dz)
        begin
            fin_r  = '0;
            fin_ov = 1'b0;
        end
        else if ((fin.func == OP_DIVS) || (fin.func == OP_NORM))
        begin
            for (int j = 0; j < 3; j++)
            begin
                qs = $signed({{(66 - DIVD_W){1'b0}}, quot[j]});
                if (tag_out[j])
                    qs = -qs;
                q_res    = sat_word(qs);
                fin_r[j] = q_res.val;
                fin_ov   = fin_ov || q_res.ov;
            end
        end
        out_next.r_x           = fin_r[0];
        out_next.r_y           = fin_r[1];
        out_next.r_z           = fin_r[2];
        out_next.scalar_out    = fin.sc;
        out_next.equal_flag    = fin.eq;
        out_next.overflow_flag = fin_ov;
        out_next.div_error     = fin.dz;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

// ===== hw/rtl/v3a_checker.sv =====
// Port-level checker for the vector ALU, bound to the top level.
// Depends on v3a_pkg and vector3_alu_assert.svh.
`timescale 1ns / 1ps
`include "vector3_alu_assert.svh"

module v3a_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               done,
    input v3a_pkg::out_item_t result
);
    import v3a_pkg::*;

    // The block takes a transaction on every cycle, so it never reports busy.
    `V3A_CHECK_NEVER(a_never_busy, busy)

    // A failed division reports zeros and nothing else.
    `V3A_CHECK_IMPLY(a_dz_zero, done && result.div_error, result.r_x == '0 && result.r_y == '0 && result.r_z == '0 && result.scalar_out == '0 && !result.equal_flag)

    `V3A_CHECK_NEVER(a_dz_no_ov, done && result.div_error && result.overflow_flag)

    // An equality transaction carries no arithmetic result.
    `V3A_CHECK_IMPLY(a_eq_clean, done && result.equal_flag, result.r_x == '0 && result.r_y == '0 && result.r_z == '0 && result.scalar_out == '0 && !result.overflow_flag)

    // Scalar and vector results never appear together.
    `V3A_CHECK_IMPLY(a_sc_excl, done && (result.scalar_out != '0), result.r_x == '0 && result.r_y == '0 && result.r_z == '0)

endmodule

bind vector3_alu v3a_checker u_v3a_checker (.*);
